>>> rtl/core/mplr_pkg.sv
// shared types and constants for the midpoint line rasterizer
`timescale 1ns / 1ps
`default_nettype none

package mplr_pkg;

   // screen coordinate width
   localparam int COORD_BITS    = 11;
   // zone-0 coordinates can be the negation of the most negative screen value
   localparam int WALK_BITS     = COORD_BITS + 1;
   localparam int EAST_BITS     = COORD_BITS + 3;
   localparam int DEC_BITS      = COORD_BITS + 4;

   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [WALK_BITS-1:0]  walk_type;
   typedef logic signed [EAST_BITS-1:0]  east_type;
   typedef logic signed [DEC_BITS-1:0]   dec_type;

   typedef enum logic [2:0] {
      ZONE0 = 3'd0,
      ZONE1 = 3'd1,
      ZONE2 = 3'd2,
      ZONE3 = 3'd3,
      ZONE4 = 3'd4,
      ZONE5 = 3'd5,
      ZONE6 = 3'd6,
      ZONE7 = 3'd7
   } zone_type;

   // one word after zone classification, endpoints already mapped to zone 0
   typedef struct packed {
      logic     op;
      zone_type zone;
      walk_type a0;
      walk_type b0;
      walk_type a1;
      walk_type ddx;
      walk_type ddy;
   } setup_type;

endpackage

`default_nettype wire

>>> rtl/core/eight_zone_midpoint_line_rasterizer_top.sv
// eight-zone midpoint line rasterizer, top level
//
// req channel: a word with req_tuser = 0 loads a line (two endpoints in
// req_tdata) and yields its first pixel; req_tuser = 1 advances the walk one
// pixel and yields it. an advance with no line loaded yields nothing.
// rsp channel: one pixel per word, rsp_tlast marks the final pixel of a line.
// a load of a zero-length line yields one pixel with rsp_tlast set.
// pipeline: a zone classification register, then the walk state and the
// result register. the pixel of an accepted word passes from the
// classification register into the result register, which drives rsp.
// one word can be accepted every cycle unless rsp stalls; the walk step
// is a single add and compare on the state registers, so advances follow
// each other at full rate. when rsp_tready is low the result register holds,
// the classification register fills and then req_tready drops; no word is
// lost or repeated. reset empties both registers and leaves no line loaded.
// a load while a line is active drops the old line.
`timescale 1ns / 1ps
`default_nettype none

module eight_zone_midpoint_line_rasterizer_top (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // start_x, start_y, end_x, end_y from bit 0 up, zero padded
   input  wire  [mplr_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // operation
   input  wire  [0:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // pixel_x, pixel_y from bit 0 up, zero padded
   output logic [mplr_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tlast
);
   import mplr_pkg::*;

   // maps a zone-0 point back to the screen and packs it
   function automatic logic [RSP_DATA_BITS-1:0] pack_pixel(zone_type z, walk_type x,
                                                           walk_type y);
      walk_type                 sx;
      walk_type                 sy;
      logic [RSP_DATA_BITS-1:0] word;
      case (z)
         ZONE0: begin sx = x;  sy = y;  end
         ZONE1: begin sx = y;  sy = x;  end
         ZONE2: begin sx = -y; sy = x;  end
         ZONE3: begin sx = -x; sy = y;  end
         ZONE4: begin sx = -x; sy = -y; end
         ZONE5: begin sx = -y; sy = -x; end
         ZONE6: begin sx = y;  sy = -x; end
         default: begin sx = x;  sy = -y; end
      endcase
      word = '0;
      word[COORD_BITS-1:0]            = sx[COORD_BITS-1:0];
      word[2*COORD_BITS-1:COORD_BITS] = sy[COORD_BITS-1:0];
      return word;
   endfunction

   // ---------------- classification stage ----------------
   logic      setup_valid_ff, setup_valid_in;
   setup_type setup_ff, setup_in;
   logic      setup_go;

   always_comb begin
      coord_type x0, y0, x1, y1;
      walk_type  dx, dy, mdx, mdy;
      logic      wide;
      x0 = coord_type'(req_tdata[COORD_BITS-1:0]);
      y0 = coord_type'(req_tdata[2*COORD_BITS-1:COORD_BITS]);
      x1 = coord_type'(req_tdata[3*COORD_BITS-1:2*COORD_BITS]);
      y1 = coord_type'(req_tdata[4*COORD_BITS-1:3*COORD_BITS]);
      dx = WALK_BITS'(x1) - WALK_BITS'(x0);
      dy = WALK_BITS'(y1) - WALK_BITS'(y0);
      mdx = (dx < 0) ? -dx : dx;
      mdy = (dy < 0) ? -dy : dy;
      wide = mdx > mdy;

      setup_in.op = req_tuser[0];
      if (dx > 0 && dy >= 0) begin
         if (wide) begin
            setup_in.zone = ZONE0;
            setup_in.a0 = WALK_BITS'(x0);  setup_in.b0 = WALK_BITS'(y0);
            setup_in.a1 = WALK_BITS'(x1);
            setup_in.ddx = dx;  setup_in.ddy = dy;
         end else begin
            setup_in.zone = ZONE1;
            setup_in.a0 = WALK_BITS'(y0);  setup_in.b0 = WALK_BITS'(x0);
            setup_in.a1 = WALK_BITS'(y1);
            setup_in.ddx = dy;  setup_in.ddy = dx;
         end
      end else if (dx <= 0 && dy > 0) begin
         if (wide) begin
            setup_in.zone = ZONE3;
            setup_in.a0 = -WALK_BITS'(x0); setup_in.b0 = WALK_BITS'(y0);
            setup_in.a1 = -WALK_BITS'(x1);
            setup_in.ddx = -dx; setup_in.ddy = dy;
         end else begin
            setup_in.zone = ZONE2;
            setup_in.a0 = WALK_BITS'(y0);  setup_in.b0 = -WALK_BITS'(x0);
            setup_in.a1 = WALK_BITS'(y1);
            setup_in.ddx = dy;  setup_in.ddy = -dx;
         end
      end else if (dx < 0 && dy <= 0) begin
         if (wide) begin
            setup_in.zone = ZONE4;
            setup_in.a0 = -WALK_BITS'(x0); setup_in.b0 = -WALK_BITS'(y0);
            setup_in.a1 = -WALK_BITS'(x1);
            setup_in.ddx = -dx; setup_in.ddy = -dy;
         end else begin
            setup_in.zone = ZONE5;
            setup_in.a0 = -WALK_BITS'(y0); setup_in.b0 = -WALK_BITS'(x0);
            setup_in.a1 = -WALK_BITS'(y1);
            setup_in.ddx = -dy; setup_in.ddy = -dx;
         end
      end else begin
         // includes the zero-length line, which lands in zone 6
         if (wide) begin
            setup_in.zone = ZONE7;
            setup_in.a0 = WALK_BITS'(x0);  setup_in.b0 = -WALK_BITS'(y0);
            setup_in.a1 = WALK_BITS'(x1);
            setup_in.ddx = dx;  setup_in.ddy = -dy;
         end else begin
            setup_in.zone = ZONE6;
            setup_in.a0 = -WALK_BITS'(y0); setup_in.b0 = WALK_BITS'(x0);
            setup_in.a1 = -WALK_BITS'(y1);
            setup_in.ddx = -dy; setup_in.ddy = dx;
         end
      end
   end

   assign setup_go   = setup_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !setup_valid_ff || setup_go;

   always_comb begin
      setup_valid_in = setup_valid_ff;
      if (setup_go) begin
         setup_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         setup_valid_in = 1'b1;
      end
   end

   // ---------------- walk stage and result register ----------------
   zone_type zone_ff, zone_in;
   walk_type walk_x_ff, walk_x_in;
   walk_type walk_y_ff, walk_y_in;
   walk_type stop_x_ff, stop_x_in;
   dec_type  decision_ff, decision_in;
   east_type east_step_ff, east_step_in;
   dec_type  diagonal_step_ff, diagonal_step_in;
   logic     line_active_ff, line_active_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     out_write;

   always_comb begin
      walk_type next_x;
      walk_type next_y;
      logic     done;

      zone_in          = zone_ff;
      walk_x_in        = walk_x_ff;
      walk_y_in        = walk_y_ff;
      stop_x_in        = stop_x_ff;
      decision_in      = decision_ff;
      east_step_in     = east_step_ff;
      diagonal_step_in = diagonal_step_ff;
      line_active_in   = line_active_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_last_in      = rsp_last_ff;
      out_write        = 1'b0;
      next_x           = walk_x_ff + WALK_BITS'(1);
      next_y           = walk_y_ff;
      done             = 1'b0;

      if (setup_go) begin
         if (setup_ff.op == OP_LOAD) begin
            zone_in          = setup_ff.zone;
            walk_x_in        = setup_ff.a0;
            walk_y_in        = setup_ff.b0;
            stop_x_in        = setup_ff.a1;
            east_step_in     = EAST_BITS'(setup_ff.ddy) <<< 1;
            decision_in      = (DEC_BITS'(setup_ff.ddy) <<< 1) - DEC_BITS'(setup_ff.ddx);
            diagonal_step_in = (DEC_BITS'(setup_ff.ddy) - DEC_BITS'(setup_ff.ddx)) <<< 1;
            done             = !(setup_ff.a0 < setup_ff.a1);
            line_active_in   = !done;
            rsp_data_in      = pack_pixel(setup_ff.zone, setup_ff.a0, setup_ff.b0);
            rsp_last_in      = done;
            out_write        = 1'b1;
         end else if (line_active_ff) begin
            // east when the midpoint lies above the line, else north-east
            if (decision_ff < 0) begin
               decision_in = decision_ff + DEC_BITS'(east_step_ff);
            end else begin
               next_y      = walk_y_ff + WALK_BITS'(1);
               decision_in = decision_ff + diagonal_step_ff;
            end
            walk_x_in      = next_x;
            walk_y_in      = next_y;
            done           = !(next_x < stop_x_ff);
            line_active_in = !done;
            rsp_data_in    = pack_pixel(zone_ff, next_x, next_y);
            rsp_last_in    = done;
            out_write      = 1'b1;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_write) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_valid_ff <= 1'b0;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         setup_valid_ff <= setup_valid_in;
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      setup_ff         <= (req_tvalid && req_tready) ? setup_in : setup_ff;
      zone_ff          <= zone_in;
      walk_x_ff        <= walk_x_in;
      walk_y_ff        <= walk_y_in;
      stop_x_ff        <= stop_x_in;
      decision_ff      <= decision_in;
      east_step_ff     <= east_step_in;
      diagonal_step_ff <= diagonal_step_in;
      rsp_data_ff      <= rsp_data_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- checks ----------------
   a_load_yields_pixel: assert property (@(posedge clock) disable iff (reset)
      setup_go && setup_ff.op == OP_LOAD |=> rsp_tvalid)
      else $error("load word did not produce a pixel");

   a_idle_advance_silent: assert property (@(posedge clock) disable iff (reset)
      setup_go && setup_ff.op == OP_ADVANCE && !line_active_ff |=> !rsp_tvalid)
      else $error("advance with no line produced a pixel");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      out_write && rsp_last_in |=> !line_active_ff)
      else $error("line still active after its last pixel");

   a_active_before_stop: assert property (@(posedge clock) disable iff (reset)
      line_active_ff |-> walk_x_ff < stop_x_ff)
      else $error("active line already at its end x");

endmodule

`default_nettype wire
